// File: design/rde_pkg.sv
// shared constants and types for the ring deque engine
`timescale 1ns / 1ps

package rde_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W = 32;

    typedef logic [2:0] op_t;
    typedef logic [1:0] status_t;

    localparam op_t OP_PUSH_FRONT = 3'd0;
    localparam op_t OP_PUSH_BACK  = 3'd1;
    localparam op_t OP_POP_FRONT  = 3'd2;
    localparam op_t OP_POP_BACK   = 3'd3;
    localparam op_t OP_DUMP       = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

// File: design/rde_if.sv
// request and response channel interfaces of the ring deque engine
`timescale 1ns / 1ps

interface rde_req_if;
    logic                             valid;
    logic                             ready;
    rde_pkg::op_t                     op;
    logic signed [rde_pkg::DATA_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink (input valid, input op, input value, output ready);
endinterface

interface rde_rsp_if;
    logic                             valid;
    logic                             ready;
    logic signed [rde_pkg::DATA_W-1:0] item;
    rde_pkg::status_t                 status;
    logic                             last;

    modport source (output valid, output item, output status, output last, input ready);
    modport sink (input valid, input item, input status, input last, output ready);
endinterface

// File: design/ring_deque_engine_top.sv
// ring deque engine: bounded double-ended queue of 32-bit words in a ring memory
`timescale 1ns / 1ps

// push, refused push or empty status: response registered, valid in the cycle after accept
// pop: ring read into rd_data_reg, then S_POP loads it into the output register once free
// dump: per element S_DUMP_RD reads, S_DUMP_OUT loads (read, then load); one request word at a time
// a request is taken only while the sequencer is idle and the output register is empty or being drained
// reset (async, active low) clears state, indexes, count and output valid, not the ring memory

module ring_deque_engine_top #(
    parameter int DEPTH = rde_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    rde_req_if.sink     req,
    rde_rsp_if.source   rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int DW = rde_pkg::DATA_W;

    // one-hot sequencer states
    typedef enum logic [3:0] {
        S_IDLE     = 4'b0001,
        S_POP      = 4'b0010,
        S_DUMP_RD  = 4'b0100,
        S_DUMP_OUT = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     front_reg, front_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     dump_idx_reg, dump_idx_next;

    // output register
    logic              rsp_valid_reg, rsp_valid_next;
    logic signed [DW-1:0] item_reg, item_next;
    rde_pkg::status_t  status_reg, status_next;
    logic              last_reg, last_next;

    // ring memory with registered read data
    logic [DW-1:0]     ring_mem [DEPTH];
    logic [DW-1:0]     rd_data_reg;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [DW-1:0]     mem_wdata;

    logic              req_fire;
    logic              out_free;
    logic              is_full, is_empty;
    logic [AW-1:0]     count_lo;
    logic [AW-1:0]     front_dec;
    logic [AW-1:0]     dump_last_idx;

    // wrap a sum of two in-range offsets back into the ring
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW + 1)'(DEPTH))
            s = s - (AW + 1)'(DEPTH);
        return s[AW-1:0];
    endfunction

    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign req_fire  = req.valid && req.ready;

    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign count_lo  = count_reg[AW-1:0];
    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    // only meaningful while the queue is not empty
    assign dump_last_idx = AW'(count_reg - CW'(1));

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        dump_idx_next  = dump_idx_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        item_next      = item_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = front_reg;
        mem_raddr      = front_reg;
        mem_wdata      = req.value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req.op) inside
                        rde_pkg::OP_PUSH_FRONT, rde_pkg::OP_PUSH_BACK:
                        begin
                            rsp_valid_next = 1'b1;
                            item_next      = '0;
                            last_next      = 1'b1;
                            if (is_full)
                                status_next = rde_pkg::ST_FULL;
                            else
                            begin
                                status_next = rde_pkg::ST_OK;
                                mem_we      = 1'b1;
                                count_next  = count_reg + CW'(1);
                                if (req.op == rde_pkg::OP_PUSH_FRONT)
                                begin
                                    mem_waddr  = front_dec;
                                    front_next = front_dec;
                                end
                                else
                                    mem_waddr = wrap_add(front_reg, count_lo);
                            end
                        end
                        rde_pkg::OP_POP_FRONT, rde_pkg::OP_POP_BACK, rde_pkg::OP_DUMP:
                        begin
                            if (is_empty)
                            begin
                                rsp_valid_next = 1'b1;
                                item_next      = '0;
                                status_next    = rde_pkg::ST_EMPTY;
                                last_next      = 1'b1;
                            end
                            else if (req.op == rde_pkg::OP_DUMP)
                            begin
                                dump_idx_next = '0;
                                state_next    = S_DUMP_RD;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                count_next = count_reg - CW'(1);
                                state_next = S_POP;
                                if (req.op == rde_pkg::OP_POP_FRONT)
                                begin
                                    mem_raddr  = front_reg;
                                    front_next = wrap_add(front_reg, AW'(1));
                                end
                                else
                                    mem_raddr = wrap_add(front_reg, dump_last_idx);
                            end
                        end
                        default:
                        begin
                            // unused codes are dropped without a response
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    item_next      = rd_data_reg;
                    status_next    = rde_pkg::ST_OK;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DUMP_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = wrap_add(front_reg, dump_idx_reg);
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    item_next      = rd_data_reg;
                    status_next    = rde_pkg::ST_OK;
                    last_next      = (dump_idx_reg == dump_last_idx);
                    if (dump_idx_reg == dump_last_idx)
                        state_next = S_IDLE;
                    else
                    begin
                        dump_idx_next = dump_idx_reg + AW'(1);
                        state_next    = S_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    // ring memory: one write port, one read port with registered data
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= ring_mem[mem_raddr];
    end

    assign rsp.valid  = rsp_valid_reg;
    assign rsp.item   = item_reg;
    assign rsp.status = status_reg;
    assign rsp.last   = last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg < AW'(DEPTH - 1) || front_reg == AW'(DEPTH - 1))
        else $error("front index out of ring");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && !is_full
        && (req.op == rde_pkg::OP_PUSH_FRONT || req.op == rde_pkg::OP_PUSH_BACK)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("accepted push did not grow the queue");

    a_dump_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP_RD || state_reg == S_DUMP_OUT)
        |-> !is_empty && {1'b0, dump_idx_reg} < (AW + 1)'(count_reg))
        else $error("dump index past the back of the queue");

    a_pop_response: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POP && out_free
        |=> rsp_valid_reg && last_reg && status_reg == rde_pkg::ST_OK)
        else $error("pop response not issued");
`endif

endmodule

// File: verif/tb.sv
// testbench for the ring deque engine: random deque traffic checked against a local deque model
`timescale 1ns / 1ps

module tb;
    import rde_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int N_ITEMS     = 420;   // counted deque ops, directed part included
    localparam int HOLD_AT     = 100;   // response word count that starts the long hold-off
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_TAIL  = 20;
    localparam int IDLE_LIMIT  = 3000;

    // op codes 5 to 7 carry no operation
    localparam op_t OP_UNUSED_LO = 3'd5;

    typedef struct {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
        int                       gap;
    } req_word_t;

    typedef struct {
        logic signed [DATA_W-1:0] item;
        status_t                  status;
        logic                     last;
    } rsp_word_t;

    logic clk;
    logic rst_n;

    rde_req_if req_ch ();
    rde_rsp_if rsp_ch ();

    ring_deque_engine_top #(.DEPTH(DEPTH)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // stimulus waiting to be offered and response words still owed by the block
    req_word_t pending_reqs[$];
    rsp_word_t owed_words[$];

    // deque model state
    logic signed [DATA_W-1:0] ring [DEPTH];
    logic [5:0]               head;
    logic [6:0]               fill_cnt;

    // bookkeeping
    int  mismatches;
    int  reqs_taken;
    int  total_reqs;
    int  words_seen;
    int  refused_pushes;
    int  empty_reports;
    int  full_dumps;
    int  peak_fill;
    int  idle_cycles;

    // generator state
    int  gen_fill;
    int  real_items;
    bit  req_burst;

    // driver and monitor state
    req_word_t staged_req;
    bit        have_staged;
    int        gap_left;
    int        rsp_wait;
    int        hold_left;
    bit        rsp_burst;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void add_owed_word(logic signed [DATA_W-1:0] item, status_t status,
                                          logic last);
        rsp_word_t w;
        w.item   = item;
        w.status = status;
        w.last   = last;
        owed_words.push_back(w);
    endfunction

    // deque behavior, one accepted request at a time
    function automatic void predict_words(op_t op, logic signed [DATA_W-1:0] value);
        int slot;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
                if (fill_cnt == DEPTH)
                begin
                    add_owed_word('0, ST_FULL, 1'b1);
                    refused_pushes++;
                end
                else
                begin
                    if (op == OP_PUSH_FRONT)
                    begin
                        head = 6'((int'(head) + DEPTH - 1) % DEPTH);
                        slot = int'(head);
                    end
                    else
                        slot = (int'(head) + int'(fill_cnt)) % DEPTH;
                    ring[slot] = value;
                    fill_cnt++;
                    if (int'(fill_cnt) > peak_fill)
                        peak_fill = int'(fill_cnt);
                    add_owed_word('0, ST_OK, 1'b1);
                end
            OP_POP_FRONT, OP_POP_BACK:
                if (fill_cnt == 0)
                begin
                    add_owed_word('0, ST_EMPTY, 1'b1);
                    empty_reports++;
                end
                else
                begin
                    if (op == OP_POP_FRONT)
                    begin
                        slot = int'(head);
                        head = 6'((int'(head) + 1) % DEPTH);
                    end
                    else
                        slot = (int'(head) + int'(fill_cnt) - 1) % DEPTH;
                    fill_cnt--;
                    add_owed_word(ring[slot], ST_OK, 1'b1);
                end
            OP_DUMP:
                if (fill_cnt == 0)
                begin
                    add_owed_word('0, ST_EMPTY, 1'b1);
                    empty_reports++;
                end
                else
                begin
                    for (int i = 0; i < fill_cnt; i++)
                        add_owed_word(ring[(int'(head) + i) % DEPTH], ST_OK,
                                      (i + 1 == fill_cnt));
                    if (fill_cnt == DEPTH)
                        full_dumps++;
                end
            default:
                ;   // unused codes: no word, no change
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // queue a request and track the fill level it will leave behind
    function automatic void add_req(op_t op, logic signed [DATA_W-1:0] value);
        req_word_t r;
        r.op    = op;
        r.value = value;
        r.gap   = req_burst ? 0 : $urandom_range(0, 15);
        pending_reqs.push_back(r);
        if ((op == OP_PUSH_FRONT || op == OP_PUSH_BACK) && gen_fill < DEPTH)
            gen_fill++;
        else if ((op == OP_POP_FRONT || op == OP_POP_BACK) && gen_fill > 0)
            gen_fill--;
        if (op <= OP_DUMP)
            real_items++;
    endfunction

    function automatic op_t pick_push();
        return ($urandom_range(0, 1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    endfunction

    function automatic op_t pick_pop();
        return ($urandom_range(0, 1) != 0) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    function automatic op_t pick_unused();
        return op_t'(OP_UNUSED_LO + $urandom_range(0, 2));
    endfunction

    // request driver: one staged word, optional gap, then hold valid until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.op    <= OP_PUSH_FRONT;
            req_ch.value <= '0;
            have_staged  = 1'b0;
            gap_left     = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_words(req_ch.op, req_ch.value);
                reqs_taken++;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (!have_staged && pending_reqs.size() > 0)
                begin
                    staged_req  = pending_reqs.pop_front();
                    have_staged = 1'b1;
                    gap_left    = staged_req.gap;
                end
                if (have_staged && gap_left == 0)
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.op    <= staged_req.op;
                    req_ch.value <= staged_req.value;
                    have_staged  = 1'b0;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                    if (have_staged)
                        gap_left--;
                end
            end
        end
    end

    // response monitor: checks each word and throttles ready
    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t w;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_wait     = 0;
            hold_left    = 0;
            rsp_burst    = 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (owed_words.size() == 0)
                begin
                    $error("unexpected response word: item %0d status %0d last %0d",
                           rsp_ch.item, rsp_ch.status, rsp_ch.last);
                    mismatches++;
                end
                else
                begin
                    w = owed_words.pop_front();
                    if (rsp_ch.item !== w.item)
                    begin
                        $error("item: expected %0d, got %0d", w.item, rsp_ch.item);
                        mismatches++;
                    end
                    if (rsp_ch.status !== w.status)
                    begin
                        $error("status: expected %0d, got %0d", w.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.last !== w.last)
                    begin
                        $error("last: expected %0d, got %0d", w.last, rsp_ch.last);
                        mismatches++;
                    end
                end
                words_seen++;
                // one long back-pressure stretch so the block stalls its request side
                if (words_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
                if ($urandom_range(0, 31) == 0)
                    rsp_burst = !rsp_burst;
                rsp_wait = rsp_burst ? 0 : $urandom_range(0, 15);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rsp_wait > 0)
            begin
                rsp_wait--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("no progress for %0d cycles", IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        int kind;
        int reps;
        int r;
        bit first_seq;

        mismatches     = 0;
        reqs_taken     = 0;
        words_seen     = 0;
        refused_pushes = 0;
        empty_reports  = 0;
        full_dumps     = 0;
        peak_fill      = 0;
        idle_cycles    = 0;
        head           = '0;
        fill_cnt       = '0;
        gen_fill       = 0;
        real_items     = 0;

        // directed: empty cases, extremes, both ends, unused codes
        req_burst = 1'b1;
        add_req(OP_DUMP, '0);
        add_req(OP_POP_FRONT, '0);
        add_req(OP_POP_BACK, '1);
        add_req(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        add_req(OP_PUSH_BACK, 32'sh8000_0000);
        add_req(OP_PUSH_FRONT, '1);
        add_req(OP_PUSH_BACK, '0);
        add_req(OP_PUSH_FRONT, 32'sh0000_0001);
        add_req(OP_DUMP, '0);
        add_req(OP_POP_FRONT, '0);
        add_req(OP_POP_BACK, '0);
        add_req(OP_UNUSED_LO, $urandom);
        add_req(op_t'(OP_UNUSED_LO + 1), $urandom);
        add_req(op_t'(OP_UNUSED_LO + 2), $urandom);
        add_req(OP_DUMP, '0);
        add_req(OP_POP_FRONT, '0);
        add_req(OP_POP_BACK, '0);
        add_req(OP_POP_FRONT, '0);
        add_req(OP_POP_BACK, '0);
        add_req(OP_DUMP, '0);

        // random: fill-to-full, drain-to-empty and mixed runs, with some noise
        first_seq = 1'b1;
        while (real_items < N_ITEMS)
        begin
            kind      = first_seq ? 0 : $urandom_range(0, 9);
            first_seq = 1'b0;
            req_burst = ($urandom_range(0, 2) == 0);
            if (kind <= 1)
            begin
                while (gen_fill < DEPTH)
                    add_req(pick_push(), pick_value());
                reps = $urandom_range(1, 3);
                repeat (reps)
                    add_req(pick_push(), pick_value());
                add_req(OP_DUMP, pick_value());
            end
            else if (kind <= 3)
            begin
                while (gen_fill > 0)
                    add_req(pick_pop(), pick_value());
                reps = $urandom_range(1, 2);
                repeat (reps)
                    add_req(pick_pop(), pick_value());
                if ($urandom_range(0, 1) != 0)
                    add_req(OP_DUMP, pick_value());
            end
            else if (kind <= 8)
            begin
                reps = $urandom_range(8, 24);
                repeat (reps)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 22)
                        add_req(OP_PUSH_FRONT, pick_value());
                    else if (r < 44)
                        add_req(OP_PUSH_BACK, pick_value());
                    else if (r < 64)
                        add_req(OP_POP_FRONT, pick_value());
                    else if (r < 84)
                        add_req(OP_POP_BACK, pick_value());
                    else if (r < 94)
                        add_req(OP_DUMP, pick_value());
                    else
                        add_req(pick_unused(), pick_value());
                end
            end
            else
            begin
                reps = $urandom_range(1, 4);
                repeat (reps)
                    add_req(pick_unused(), pick_value());
            end
        end
        total_reqs = pending_reqs.size();

        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (reqs_taken != total_reqs)
            @(posedge clk);
        while (owed_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        $display("ran %0d requests, checked %0d response words", reqs_taken, words_seen);
        $display("%0d refused pushes, %0d empty reports, %0d full-queue dumps, peak fill %0d",
                 refused_pushes, empty_reports, full_dumps, peak_fill);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
